// ===== rtl/core/circle_center_from_three_points_top_assert.svh =====
// Assertion macros shared by the circle center RTL.
`ifndef CIRCLE_CENTER_FROM_THREE_POINTS_TOP_ASSERT_SVH
`define CIRCLE_CENTER_FROM_THREE_POINTS_TOP_ASSERT_SVH

`define CFC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define CFC_ASSERT_ALWAYS(lbl, cond, msg) \
  `CFC_ASSERT_IMPL(lbl, 1'b1, cond, msg)

`endif

// ===== rtl/core/cfc_pkg.sv =====
package cfc_pkg;

  localparam int ST_W = 2;

  typedef enum logic [ST_W-1:0] {
    ST_OK         = 2'd0,
    ST_COINCIDENT = 2'd1,
    ST_COLLINEAR  = 2'd2
  } status_t;

  localparam int MUL_DIG = 8;

endpackage

// ===== rtl/core/circle_center_from_three_points_top.sv =====
// Circle center and plane normal from three points in space.
// Input channel: in_valid/in_ready carry a start, a pass-through and an end
// point, each coordinate signed fixed point with FRAC_BITS fraction bits.
// Output channel: out_valid/out_ready carry status, the circle center and the
// plane normal in the same format as the inputs, saturated to COORD_WIDTH bits.
// One transaction is accepted every cycle while the output side keeps up.
// The 2*COORD_WIDTH+5 bit coefficient multiplier and the COORD_WIDTH+1 bit center
// multiplier both work at 8 bits per stage. The long part is the restoring
// divider, which resolves one quotient bit per pipeline stage in each lane.
// Three lanes handle the x, y and z components side by side.
// Reset clears all valid flags; payload registers are not reset.
// When the receiver stalls, the pipeline keeps moving and absorbs bubbles until
// a finished result reaches the last stage; only then does in_ready drop.
`include "circle_center_from_three_points_top_assert.svh"

module circle_center_from_three_points_top #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] start_x,
  input  logic signed [COORD_WIDTH-1:0] start_y,
  input  logic signed [COORD_WIDTH-1:0] start_z,
  input  logic signed [COORD_WIDTH-1:0] via_x,
  input  logic signed [COORD_WIDTH-1:0] via_y,
  input  logic signed [COORD_WIDTH-1:0] via_z,
  input  logic signed [COORD_WIDTH-1:0] end_x,
  input  logic signed [COORD_WIDTH-1:0] end_y,
  input  logic signed [COORD_WIDTH-1:0] end_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    status,
  output logic signed [COORD_WIDTH-1:0] center_x,
  output logic signed [COORD_WIDTH-1:0] center_y,
  output logic signed [COORD_WIDTH-1:0] center_z,
  output logic signed [COORD_WIDTH-1:0] normal_x,
  output logic signed [COORD_WIDTH-1:0] normal_y,
  output logic signed [COORD_WIDTH-1:0] normal_z
);

  import cfc_pkg::*;

  localparam int W    = COORD_WIDTH;
  localparam int F    = FRAC_BITS;
  localparam int AW   = W + 1;
  localparam int PW   = 2 * AW;
  localparam int NW   = PW + 1;
  localparam int SW2  = PW + 2;
  localparam int DW   = SW2 + 1;
  localparam int KW   = SW2 + DW;
  localparam int NNP  = 2 * NW;
  localparam int LK   = (DW + MUL_DIG - 1) / MUL_DIG;
  localparam int LN   = (NW + MUL_DIG - 1) / MUL_DIG;
  localparam int KD   = 3 + LK;
  localparam int TW   = W + ST_W;

  localparam logic signed [NW+1:0] NMAX = {{(NW-W+2){1'b0}}, {W{1'b1}}} >> 1;
  localparam logic signed [NW+1:0] NMIN = ~NMAX;

  logic en;

  logic signed [W-1:0]    pin [3];
  logic signed [W-1:0]    qin [3];
  logic signed [W-1:0]    rin [3];
  logic signed [AW-1:0]   a_l [3];
  logic signed [AW-1:0]   b_l [3];
  logic signed [PW-1:0]   aa_l [3];
  logic signed [PW-1:0]   bb_l [3];
  logic signed [PW-1:0]   ab_l [3];
  logic signed [PW-1:0]   t2 [3];
  logic signed [PW-1:0]   u2 [3];
  logic signed [NW-1:0]   n3 [3];
  logic signed [NW-1:0]   n4 [3];
  logic signed [W-1:0]    nrm_c [3];
  logic signed [W-1:0]    nrm4 [3];
  logic signed [NNP-1:0]  nn4 [3];
  logic signed [NNP-1:0]  nnk [3];
  logic [TW-1:0]          tagk [3];
  logic                   lv [3];
  logic signed [W-1:0]    cen [3];
  logic [TW-1:0]          tago [3];

  logic                   v1, v2, v3, v4, vk;
  logic                   coin1, coin2, coin3;
  logic signed [SW2-1:0]  aa3, bb3, ab3, aa4, bb4;
  logic signed [DW-1:0]   amab4, bmab4;
  status_t                st4;
  logic signed [KW-1:0]   ka, kb;
  logic [KW-1:0]          den;

  assign en       = !(lv[0] && out_valid && !out_ready);
  assign in_ready = en;

  assign pin[0] = start_x;
  assign pin[1] = start_y;
  assign pin[2] = start_z;
  assign qin[0] = via_x;
  assign qin[1] = via_y;
  assign qin[2] = via_z;
  assign rin[0] = end_x;
  assign rin[1] = end_y;
  assign rin[2] = end_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      coin1 <= (start_x == via_x && start_y == via_y && start_z == via_z) ||
               (start_x == end_x && start_y == end_y && start_z == end_z) ||
               (via_x == end_x && via_y == end_y && via_z == end_z);
      coin2 <= coin1;
      coin3 <= coin2;
      aa3   <= SW2'(aa_l[0]) + SW2'(aa_l[1]) + SW2'(aa_l[2]);
      bb3   <= SW2'(bb_l[0]) + SW2'(bb_l[1]) + SW2'(bb_l[2]);
      ab3   <= SW2'(ab_l[0]) + SW2'(ab_l[1]) + SW2'(ab_l[2]);
      amab4 <= DW'(aa3) - DW'(ab3);
      bmab4 <= DW'(bb3) - DW'(ab3);
      aa4   <= aa3;
      bb4   <= bb3;
      if (coin3) begin
        st4 <= ST_COINCIDENT;
      end else if (n3[0] == '0 && n3[1] == '0 && n3[2] == '0) begin
        st4 <= ST_COLLINEAR;
      end else begin
        st4 <= ST_OK;
      end
    end
  end

  genvar i;
  generate
    for (i = 0; i < 3; i++) begin : g_comp
      localparam int J = (i + 1) % 3;
      localparam int K = (i + 2) % 3;

      logic [NW-1:0]          nmag;
      logic [NW:0]            nm, nq;
      logic signed [NW+1:0]   nv;

      cfc_lane #(.W(W), .KD(KD), .DIG(MUL_DIG)) u_lane (
        .clk (clk), .rst (rst), .en (en),
        .p (pin[i]), .q (qin[i]), .r (rin[i]),
        .a (a_l[i]), .b (b_l[i]), .aa (aa_l[i]), .bb (bb_l[i]), .ab (ab_l[i]),
        .ka (ka), .kb (kb), .vk (vk), .tag (tagk[i]), .den (den),
        .vo (lv[i]), .center (cen[i]), .tag_o (tago[i])
      );

      assign nmag = n3[i][NW-1] ? NW'(-n3[i]) : NW'(n3[i]);
      assign nm   = (NW+1)'({nmag, 1'b0}) + ((NW+1)'(1) << F);
      assign nq   = nm >> (F + 1);
      assign nv   = n3[i][NW-1] ? -(NW+2)'(nq) : (NW+2)'(nq);

      always_comb begin
        if (nv > NMAX) begin
          nrm_c[i] = {1'b0, {(W-1){1'b1}}};
        end else if (nv < NMIN) begin
          nrm_c[i] = {1'b1, {(W-1){1'b0}}};
        end else begin
          nrm_c[i] = nv[W-1:0];
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          t2[i]   <= PW'(a_l[J]) * PW'(b_l[K]);
          u2[i]   <= PW'(a_l[K]) * PW'(b_l[J]);
          n3[i]   <= NW'(t2[i]) - NW'(u2[i]);
          n4[i]   <= n3[i];
          nrm4[i] <= nrm_c[i];
        end
      end

      cfc_mul #(.WA(NW), .WB(NW), .DIG(MUL_DIG)) u_sq (
        .clk (clk), .en (en), .a (n4[i]), .b (n4[i]), .p (nn4[i])
      );

      cfc_dly #(.W(NNP), .N(LK-LN)) u_nndly (
        .clk (clk), .rst (rst), .en (en), .d (nn4[i]), .q (nnk[i])
      );

      cfc_dly #(.W(TW), .N(LK)) u_tagdly (
        .clk (clk), .rst (rst), .en (en), .d ({st4, nrm4[i]}), .q (tagk[i])
      );
    end
  endgenerate

  cfc_mul #(.WA(SW2), .WB(DW), .DIG(MUL_DIG)) u_ka (
    .clk (clk), .en (en), .a (bb4), .b (amab4), .p (ka)
  );

  cfc_mul #(.WA(SW2), .WB(DW), .DIG(MUL_DIG)) u_kb (
    .clk (clk), .en (en), .a (aa4), .b (bmab4), .p (kb)
  );

  cfc_dly #(.W(1), .N(LK), .RST_EN(1'b1)) u_vkdly (
    .clk (clk), .rst (rst), .en (en), .d (v4), .q (vk)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      den <= (KW'(nnk[0]) + KW'(nnk[1]) + KW'(nnk[2])) << 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= lv[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      status   <= tago[0][TW-1 -: ST_W];
      center_x <= cen[0];
      center_y <= cen[1];
      center_z <= cen[2];
      normal_x <= tago[0][W-1:0];
      normal_y <= tago[1][W-1:0];
      normal_z <= tago[2][W-1:0];
    end
  end

  `CFC_ASSERT_ALWAYS(a_lane_vld, lv[0] == lv[1] && lv[1] == lv[2], "lanes out of step")
  `CFC_ASSERT_IMPL(a_lane_st, lv[0], tago[0][TW-1 -: ST_W] == tago[1][TW-1 -: ST_W] && tago[1][TW-1 -: ST_W] == tago[2][TW-1 -: ST_W], "lane status mismatch")
  `CFC_ASSERT_IMPL(a_bad_zero, out_valid && status != ST_OK, center_x == '0 && center_y == '0 && center_z == '0, "center not zero on bad status")
  `CFC_ASSERT_IMPL(a_col_nrm, out_valid && status != ST_OK, normal_x == '0 && normal_y == '0 && normal_z == '0, "normal not zero on bad status")
  `CFC_ASSERT_IMPL(a_stall, lv[0] && out_valid && !out_ready, !in_ready, "input taken while result blocked")

endmodule

// ===== rtl/core/cfc_dly.sv =====
module cfc_dly #(
  parameter int W      = 1,
  parameter int N      = 1,
  parameter bit RST_EN = 1'b0
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  generate
    if (N == 0) begin : g_pass
      assign q = d;
    end else begin : g_line
      logic [W-1:0] line [N];
      always_ff @(posedge clk) begin
        if (RST_EN && rst) begin
          for (int i = 0; i < N; i++) line[i] <= '0;
        end else if (en) begin
          line[0] <= d;
          for (int i = 1; i < N; i++) line[i] <= line[i-1];
        end
      end
      assign q = line[N-1];
    end
  endgenerate

endmodule

// ===== rtl/core/cfc_mul.sv =====
module cfc_mul #(
  parameter int WA  = 33,
  parameter int WB  = 33,
  parameter int DIG = 8
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [WA-1:0]    a,
  input  logic signed [WB-1:0]    b,
  output logic signed [WA+WB-1:0] p
);

  localparam int NS = (WB + DIG - 1) / DIG;
  localparam int BE = NS * DIG;
  localparam int PW = WA + BE;

  logic signed [BE-1:0] bx;
  logic signed [PW-1:0] acc  [NS];
  logic signed [WA-1:0] areg [NS-1];
  logic signed [BE-1:0] breg [NS-1];

  assign bx = BE'(b);

  genvar k;
  generate
    for (k = 0; k < NS; k++) begin : g_st
      logic signed [WA-1:0] sa;
      logic signed [BE-1:0] sb;
      logic [DIG-1:0]       dg;
      logic signed [PW-1:0] ax, dx, prev, term;

      if (k == 0) begin : g_first
        assign sa   = a;
        assign sb   = bx;
        assign prev = '0;
      end else begin : g_next
        assign sa   = areg[k-1];
        assign sb   = breg[k-1];
        assign prev = acc[k-1];
      end

      assign dg = sb[DIG*k +: DIG];

      if (k == NS - 1) begin : g_sgn
        assign dx = PW'($signed(dg));
      end else begin : g_uns
        assign dx = PW'($signed({1'b0, dg}));
      end

      assign ax   = PW'(sa);
      assign term = (ax * dx) <<< (DIG * k);

      always_ff @(posedge clk) begin
        if (en) begin
          acc[k] <= prev + term;
        end
      end

      if (k < NS - 1) begin : g_fwd
        always_ff @(posedge clk) begin
          if (en) begin
            areg[k] <= sa;
            breg[k] <= sb;
          end
        end
      end
    end
  endgenerate

  assign p = acc[NS-1][WA+WB-1:0];

endmodule

// ===== rtl/core/cfc_div.sv =====
module cfc_div #(
  parameter int NUMW = 171,
  parameter int DENW = 137,
  parameter int QB   = 33,
  parameter int SW   = 98
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   vi,
  input  logic signed [NUMW-1:0] num,
  input  logic [DENW-1:0]        den,
  input  logic [SW-1:0]          si,
  output logic                   vo,
  output logic [QB-1:0]          q,
  output logic                   ovf,
  output logic                   neg,
  output logic [SW-1:0]          so
);

  localparam int DW2 = DENW + 1;
  localparam int MW  = (NUMW + 1 > DW2 + QB) ? NUMW + 1 : DW2 + QB;

  logic [NUMW-1:0] mag;
  logic [MW-1:0]   m0;
  logic [DW2-1:0]  d0;
  logic            n0, v0;
  logic [SW-1:0]   s0;

  logic [MW-1:0]   r_s [QB];
  logic [DW2-1:0]  d_s [QB];
  logic [QB-1:0]   q_s [QB+1];
  logic            o_s [QB+1];
  logic            n_s [QB+1];
  logic [SW-1:0]   s_s [QB+1];
  logic            v_s [QB+1];

  assign mag = num[NUMW-1] ? NUMW'(-num) : NUMW'(num);

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= vi;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m0 <= MW'({mag, 1'b0}) + MW'(den);
      d0 <= {den, 1'b0};
      n0 <= num[NUMW-1];
      s0 <= si;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_s[0] <= 1'b0;
    end else if (en) begin
      v_s[0] <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_s[0] <= m0;
      d_s[0] <= d0;
      q_s[0] <= '0;
      o_s[0] <= (m0 >= (MW'(d0) << QB));
      n_s[0] <= n0;
      s_s[0] <= s0;
    end
  end

  genvar j;
  generate
    for (j = 1; j <= QB; j++) begin : g_bit
      localparam int SH = QB - j;
      logic [MW-1:0] sub;
      logic          ge;

      assign sub = MW'(d_s[j-1]) << SH;
      assign ge  = (r_s[j-1] >= sub);

      always_ff @(posedge clk) begin
        if (rst) begin
          v_s[j] <= 1'b0;
        end else if (en) begin
          v_s[j] <= v_s[j-1];
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          q_s[j] <= {q_s[j-1][QB-2:0], ge};
          o_s[j] <= o_s[j-1];
          n_s[j] <= n_s[j-1];
          s_s[j] <= s_s[j-1];
        end
      end

      if (j < QB) begin : g_rem
        always_ff @(posedge clk) begin
          if (en) begin
            r_s[j] <= ge ? (r_s[j-1] - sub) : r_s[j-1];
            d_s[j] <= d_s[j-1];
          end
        end
      end
    end
  endgenerate

  assign vo  = v_s[QB];
  assign q   = q_s[QB];
  assign ovf = o_s[QB];
  assign neg = n_s[QB];
  assign so  = s_s[QB];

endmodule

// ===== rtl/core/cfc_lane.sv =====
module cfc_lane #(
  parameter int W   = 32,
  parameter int KD  = 12,
  parameter int DIG = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic signed [W-1:0]           p,
  input  logic signed [W-1:0]           q,
  input  logic signed [W-1:0]           r,
  output logic signed [W:0]             a,
  output logic signed [W:0]             b,
  output logic signed [2*W+1:0]         aa,
  output logic signed [2*W+1:0]         bb,
  output logic signed [2*W+1:0]         ab,
  input  logic signed [4*W+8:0]         ka,
  input  logic signed [4*W+8:0]         kb,
  input  logic                          vk,
  input  logic [W+cfc_pkg::ST_W-1:0]    tag,
  input  logic [4*W+8:0]                den,
  output logic                          vo,
  output logic signed [W-1:0]           center,
  output logic [W+cfc_pkg::ST_W-1:0]    tag_o
);

  import cfc_pkg::*;

  localparam int AW   = W + 1;
  localparam int PW   = 2 * AW;
  localparam int KW   = 4 * W + 9;
  localparam int PRW  = KW + AW;
  localparam int NUMW = PRW + 1;
  localparam int QB   = W + 1;
  localparam int TW   = W + ST_W;
  localparam int SW   = TW + W;
  localparam int LC   = (AW + DIG - 1) / DIG;
  localparam int W3   = W + 3;

  localparam logic signed [W3-1:0] CMAX = {4'b0000, {(W-1){1'b1}}};
  localparam logic signed [W3-1:0] CMIN = {4'b1111, {(W-1){1'b0}}};

  logic signed [W-1:0]     p1;
  logic [2*AW+W-1:0]       abp_k;
  logic signed [AW-1:0]    ak, bk;
  logic signed [W-1:0]     pk;
  logic signed [PRW-1:0]   pa, pb;
  logic                    vc;
  logic [SW-1:0]           side_c;
  logic [KW-1:0]           den_c;

  logic                    vn;
  logic signed [NUMW-1:0]  num_n;
  logic [KW-1:0]           den_n;
  logic [SW-1:0]           side_n;

  logic                    vd, ovfd, negd;
  logic [QB-1:0]           qd;
  logic [SW-1:0]           sdiv;

  logic [ST_W-1:0]         st_d;
  logic signed [W-1:0]     pd;
  logic signed [W3-1:0]    sum;
  logic signed [W-1:0]     cval;

  always_ff @(posedge clk) begin
    if (en) begin
      a  <= AW'(q) - AW'(p);
      b  <= AW'(r) - AW'(p);
      p1 <= p;
      aa <= PW'(a) * PW'(a);
      bb <= PW'(b) * PW'(b);
      ab <= PW'(a) * PW'(b);
    end
  end

  cfc_dly #(.W(2*AW+W), .N(KD)) u_kdly (
    .clk (clk), .rst (rst), .en (en), .d ({a, b, p1}), .q (abp_k)
  );

  assign ak = abp_k[2*AW+W-1 -: AW];
  assign bk = abp_k[AW+W-1 -: AW];
  assign pk = abp_k[W-1:0];

  cfc_mul #(.WA(KW), .WB(AW), .DIG(DIG)) u_mula (
    .clk (clk), .en (en), .a (ka), .b (ak), .p (pa)
  );

  cfc_mul #(.WA(KW), .WB(AW), .DIG(DIG)) u_mulb (
    .clk (clk), .en (en), .a (kb), .b (bk), .p (pb)
  );

  cfc_dly #(.W(1), .N(LC), .RST_EN(1'b1)) u_vdly (
    .clk (clk), .rst (rst), .en (en), .d (vk), .q (vc)
  );

  cfc_dly #(.W(SW), .N(LC)) u_sdly (
    .clk (clk), .rst (rst), .en (en), .d ({tag, pk}), .q (side_c)
  );

  cfc_dly #(.W(KW), .N(LC-1)) u_ddly (
    .clk (clk), .rst (rst), .en (en), .d (den), .q (den_c)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vn <= 1'b0;
    end else if (en) begin
      vn <= vc;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_n  <= NUMW'(pa) + NUMW'(pb);
      den_n  <= den_c;
      side_n <= side_c;
    end
  end

  cfc_div #(.NUMW(NUMW), .DENW(KW), .QB(QB), .SW(SW)) u_div (
    .clk (clk), .rst (rst), .en (en), .vi (vn), .num (num_n), .den (den_n),
    .si (side_n), .vo (vd), .q (qd), .ovf (ovfd), .neg (negd), .so (sdiv)
  );

  assign st_d = sdiv[SW-1 -: ST_W];
  assign pd   = sdiv[W-1:0];
  assign sum  = W3'(pd) + (negd ? -W3'(qd) : W3'(qd));

  always_comb begin
    if (st_d != ST_OK) begin
      cval = '0;
    end else if (ovfd) begin
      cval = negd ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end else if (sum > CMAX) begin
      cval = {1'b0, {(W-1){1'b1}}};
    end else if (sum < CMIN) begin
      cval = {1'b1, {(W-1){1'b0}}};
    end else begin
      cval = sum[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vo <= 1'b0;
    end else if (en) begin
      vo <= vd;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      center <= cval;
      tag_o  <= sdiv[SW-1 -: TW];
    end
  end

endmodule
